// File: sv/bec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_pkg
// shared constants, codes and types of the button event classifier
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int NUM_BUTTONS_DEFAULT = 16;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int MAX_LANES           = 16;

    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int EVENT_W   = 4;
    localparam int STAGE_W   = 2;
    localparam int CLICK_W   = 8;
    localparam int INDEX_W   = 4;
    localparam int ACTIVE_W  = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP    = 3'd4;

    // button stages
    localparam logic [STAGE_W-1:0] STAGE_IDLE  = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_DOWN  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_MULTI = 2'd2;

    // event codes
    localparam logic [EVENT_W-1:0] EV_DOWN        = 4'd0;
    localparam logic [EVENT_W-1:0] EV_CLICK       = 4'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE      = 4'd2;
    localparam logic [EVENT_W-1:0] EV_REPEAT      = 4'd3;
    localparam logic [EVENT_W-1:0] EV_SHORT_START = 4'd4;
    localparam logic [EVENT_W-1:0] EV_SHORT_UP    = 4'd5;
    localparam logic [EVENT_W-1:0] EV_LONG_START  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_LONG_UP     = 4'd7;
    localparam logic [EVENT_W-1:0] EV_HOLD        = 4'd8;
    localparam logic [EVENT_W-1:0] EV_HOLD_UP     = 4'd9;
    localparam logic [EVENT_W-1:0] EV_NONE        = 4'd10;

    localparam logic [REG_W-1:0] SHORT_PRESS_RESET = 16'd50;
    localparam logic [REG_W-1:0] LONG_PRESS_RESET  = 16'd150;
    localparam logic [REG_W-1:0] LONG_HOLD_RESET   = 16'd300;
    localparam logic [REG_W-1:0] CLICK_GAP_RESET   = 16'd20;

    typedef struct packed {
        logic [REG_W-1:0] short_press;
        logic [REG_W-1:0] long_press;
        logic [REG_W-1:0] long_hold;
        logic [REG_W-1:0] click_gap;
    } thresholds_t;

    typedef struct packed {
        logic               active;
        logic [EVENT_W-1:0] event_code;
        logic               fired;
    } lane_status_t;

    function automatic logic [EVENT_W-1:0] click_event(input logic [CLICK_W-1:0] clicks);
        logic [EVENT_W-1:0] ev;
        if (clicks < CLICK_W'(EV_REPEAT))
            ev = EVENT_W'(clicks);
        else
            ev = EV_REPEAT;
        return ev;
    endfunction

endpackage

// File: sv/bec_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_lane
// per-button stage machine with tick counter, click counter and event state
// ----------------------------------------------------------------------------
module bec_lane
    import bec_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         pressed,
    input  thresholds_t  thr,
    output lane_status_t status
);

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

    logic [STAGE_W-1:0]     stage_reg, stage_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [CLICK_W-1:0]     click_reg, click_next;
    logic [EVENT_W-1:0]     event_reg, event_next;
    logic                   fired_reg, fired_next;

    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [COUNT_WIDTH-1:0] hold_trunc;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   ge_hold, ge_long, ge_short, gt_gap;

    assign hold_trunc = COUNT_WIDTH'(thr.long_hold);
    assign tick_inc   = tick_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        stage_next = stage_reg;
        click_next = click_reg;
        event_next = event_reg;
        fired_next = 1'b0;
        tick_next  = tick_reg;

        // counter runs while not idle, all ones wraps to the hold threshold
        if (stage_reg != STAGE_IDLE)
        begin
            if (tick_inc == '1)
                tick_next = hold_trunc;
            else
                tick_next = tick_inc;
        end

        cnt_ext  = CMP_W'(tick_next);
        ge_hold  = cnt_ext >= CMP_W'(thr.long_hold);
        ge_long  = cnt_ext >= CMP_W'(thr.long_press);
        ge_short = cnt_ext >= CMP_W'(thr.short_press);
        gt_gap   = cnt_ext >  CMP_W'(thr.click_gap);

        case (stage_reg)
            STAGE_IDLE:
            begin
                if (pressed)
                begin
                    tick_next  = '0;
                    click_next = '0;
                    event_next = EV_DOWN;
                    fired_next = 1'b1;
                    stage_next = STAGE_DOWN;
                end
                else
                begin
                    event_next = EV_NONE;
                end
            end
            STAGE_DOWN:
            begin
                if (pressed)
                begin
                    if (click_reg != '0)
                    begin
                        if (gt_gap)
                        begin
                            event_next = click_event(click_reg);
                            fired_next = 1'b1;
                            tick_next  = '0;
                            click_next = '0;
                        end
                    end
                    else if (ge_hold)
                    begin
                        event_next = EV_HOLD;
                        fired_next = (event_reg != EV_HOLD);
                    end
                    else if (ge_long)
                    begin
                        event_next = EV_LONG_START;
                        fired_next = (event_reg != EV_LONG_START);
                    end
                    else if (ge_short)
                    begin
                        event_next = EV_SHORT_START;
                        fired_next = (event_reg != EV_SHORT_START);
                    end
                end
                else
                begin
                    if (ge_hold)
                    begin
                        event_next = EV_HOLD_UP;
                        fired_next = 1'b1;
                        stage_next = STAGE_IDLE;
                    end
                    else if (ge_long)
                    begin
                        event_next = EV_LONG_UP;
                        fired_next = 1'b1;
                        stage_next = STAGE_IDLE;
                    end
                    else if (ge_short)
                    begin
                        event_next = EV_SHORT_UP;
                        fired_next = 1'b1;
                        stage_next = STAGE_IDLE;
                    end
                    else
                    begin
                        stage_next = STAGE_MULTI;
                        if (click_reg != '1)
                            click_next = click_reg + CLICK_W'(1);
                    end
                end
            end
            STAGE_MULTI:
            begin
                if (pressed)
                begin
                    stage_next = STAGE_DOWN;
                    tick_next  = '0;
                end
                else if (gt_gap)
                begin
                    event_next = click_event(click_reg);
                    fired_next = 1'b1;
                    stage_next = STAGE_IDLE;
                end
            end
            default:
            begin
                // unused stage only counts ticks
                stage_next = stage_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_IDLE;
            tick_reg  <= '0;
            click_reg <= '0;
            event_reg <= EV_NONE;
            fired_reg <= 1'b0;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            tick_reg  <= tick_next;
            click_reg <= click_next;
            event_reg <= event_next;
            fired_reg <= fired_next;
        end
    end

    assign status.active     = (stage_reg != STAGE_IDLE);
    assign status.event_code = event_reg;
    assign status.fired      = fired_reg;

endmodule

// File: sv/bec_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_merge
// walks the lanes highest index first, emits one result each, counts actives
// ----------------------------------------------------------------------------
module bec_merge
    import bec_pkg::*;
#(
    parameter int LANES = MAX_LANES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lane_status_t        lane_st [LANES],
    output logic                busy,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  button_index,
    output logic [EVENT_W-1:0]  event_code,
    output logic                fired,
    output logic [ACTIVE_W-1:0] active_count,
    output logic                last
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic                busy_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [ACTIVE_W-1:0] acc_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [EVENT_W-1:0]  event_reg;
    logic                fired_reg;
    logic [ACTIVE_W-1:0] count_reg;
    logic                last_reg;

    logic                load;
    logic                at_end;
    lane_status_t        sel;
    logic [ACTIVE_W-1:0] acc_next;

    assign load     = busy_reg && (!out_valid_reg || !out_stall);
    assign at_end   = (idx_reg == '0);
    assign sel      = lane_st[idx_reg];
    assign acc_next = acc_reg + ACTIVE_W'(sel.active);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= IDX_W'(LANES - 1);
                acc_reg  <= '0;
            end
            else if (load)
            begin
                acc_reg <= acc_next;
                if (at_end)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg - IDX_W'(1);
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= INDEX_W'(idx_reg);
            event_reg <= sel.event_code;
            fired_reg <= sel.fired;
            count_reg <= at_end ? acc_next : '0;
            last_reg  <= at_end;
        end
    end

    assign busy         = busy_reg;
    assign out_valid    = out_valid_reg;
    assign button_index = index_reg;
    assign event_code   = event_reg;
    assign fired        = fired_reg;
    assign active_count = count_reg;
    assign last         = last_reg;

endmodule

// File: sv/button_event_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_classifier
// click, multi-click and long press classifier for a bank of buttons
// ----------------------------------------------------------------------------
// usage:
//   in channel  : one transaction per scan tick carrying raw_levels, bit i is
//                 the pin level of button i
//   out channel : one transaction per button, highest index first; the final
//                 one has last set and carries active_count
//   config      : cfg_write with cfg_index/cfg_data, written while idle
// timing:
//   every button lane updates its state in the cycle the tick is taken; the
//   merge stage then emits one result per cycle while out_stall is low,
//   walking the lanes once per tick, and in_stall is high for the whole
//   walk, so a new tick is taken only after the last result is loaded
// reset:
//   all buttons idle with no event, thresholds back to their defaults
// stall:
//   out_stall holds the current result and pauses the walk, nothing is lost
// ----------------------------------------------------------------------------
module button_event_classifier
    import bec_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REG_W-1:0]     raw_levels,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [INDEX_W-1:0]   button_index,
    output logic [EVENT_W-1:0]   event_code,
    output logic                 fired,
    output logic [ACTIVE_W-1:0]  active_count,
    output logic                 last
);

    localparam int LANES = (NUM_BUTTONS > MAX_LANES) ? MAX_LANES :
                           ((NUM_BUTTONS < 1) ? 1 : NUM_BUTTONS);

    logic [REG_W-1:0] mask_reg;
    thresholds_t      thr_reg;
    logic             take;
    logic             busy;
    logic [REG_W-1:0] pressed_bits;
    lane_status_t     lane_st [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg            <= '0;
            thr_reg.short_press <= SHORT_PRESS_RESET;
            thr_reg.long_press  <= LONG_PRESS_RESET;
            thr_reg.long_hold   <= LONG_HOLD_RESET;
            thr_reg.click_gap   <= CLICK_GAP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ACTIVE_LEVEL: mask_reg            <= cfg_data;
                REG_SHORT_PRESS:  thr_reg.short_press <= cfg_data;
                REG_LONG_PRESS:   thr_reg.long_press  <= cfg_data;
                REG_LONG_HOLD:    thr_reg.long_hold   <= cfg_data;
                REG_CLICK_GAP:    thr_reg.click_gap   <= cfg_data;
                default:          mask_reg            <= mask_reg;
            endcase
        end
    end

    assign in_stall     = busy;
    assign take         = in_valid && !busy;
    // pressed when the raw level matches the active level
    assign pressed_bits = ~(raw_levels ^ mask_reg);

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bec_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (take),
            .pressed (pressed_bits[i]),
            .thr     (thr_reg),
            .status  (lane_st[i])
        );
    end

    bec_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (take),
        .lane_st      (lane_st),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .button_index (button_index),
        .event_code   (event_code),
        .fired        (fired),
        .active_count (active_count),
        .last         (last)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the button event classifier
// ----------------------------------------------------------------------------
// every accepted scan tick is run through a behavioral copy of the per-button
// stage machines, which queues the sixteen reports the block should emit.
// each report taken from the output channel is compared field by field with
// the oldest queued one. stimulus is a short scripted gesture set, then
// randomized press/release gestures under several threshold settings, and a
// short full-rate soak with the top button held and button 0 tapped.
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import bec_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int SOAK_TICKS     = 8;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [INDEX_W-1:0]  button;
        logic [EVENT_W-1:0]  code;
        logic                fired;
        logic [ACTIVE_W-1:0] active;
        logic                last;
    } report_t;

    class event_scoreboard;
        logic [REG_W-1:0] level_mask;
        logic [REG_W-1:0] short_thr;
        logic [REG_W-1:0] long_thr;
        logic [REG_W-1:0] hold_thr;
        logic [REG_W-1:0] gap_thr;

        logic [MAX_LANES-1:0][STAGE_W-1:0] stage_q;
        logic [MAX_LANES-1:0][REG_W-1:0]   ticks_q;
        logic [MAX_LANES-1:0][CLICK_W-1:0] clicks_q;
        logic [MAX_LANES-1:0][EVENT_W-1:0] event_q;

        report_t expected_reports[$];
        int      errors;
        int      ticks_seen;
        int      reports_seen;

        function new();
            level_mask   = '0;
            short_thr    = SHORT_PRESS_RESET;
            long_thr     = LONG_PRESS_RESET;
            hold_thr     = LONG_HOLD_RESET;
            gap_thr      = CLICK_GAP_RESET;
            stage_q      = '0;
            ticks_q      = '0;
            clicks_q     = '0;
            for (int b = 0; b < MAX_LANES; b++)
                event_q[b] = EV_NONE;
            errors       = 0;
            ticks_seen   = 0;
            reports_seen = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
            case (idx)
                REG_ACTIVE_LEVEL: level_mask = val;
                REG_SHORT_PRESS:  short_thr  = val;
                REG_LONG_PRESS:   long_thr   = val;
                REG_LONG_HOLD:    hold_thr   = val;
                REG_CLICK_GAP:    gap_thr    = val;
                default: ;
            endcase
        endfunction

        function logic [EVENT_W-1:0] clicks_to_event(input logic [CLICK_W-1:0] taps);
            if (taps >= 8'd3)
                return EV_REPEAT;
            else if (taps == 8'd2)
                return EV_DOUBLE;
            else if (taps == 8'd1)
                return EV_CLICK;
            return EV_DOWN;
        endfunction

        // advance every button by one scan tick and queue its report
        function void classify_tick(input logic [REG_W-1:0] levels);
            logic [REG_W-1:0]    pressed_vec;
            logic [STAGE_W-1:0]  st;
            logic [REG_W-1:0]    cnt;
            logic [CLICK_W-1:0]  taps;
            logic [EVENT_W-1:0]  ev;
            logic                fire;
            logic                down;
            logic [ACTIVE_W-1:0] busy;
            report_t             r;
            pressed_vec = ~(levels ^ level_mask);
            busy = '0;
            ticks_seen++;
            for (int b = MAX_LANES - 1; b >= 0; b--) begin
                down = pressed_vec[b];
                st   = stage_q[b];
                cnt  = ticks_q[b];
                taps = clicks_q[b];
                ev   = event_q[b];
                fire = 1'b0;
                if (st != STAGE_IDLE) begin
                    cnt = cnt + 16'd1;
                    // counter wraps back to the hold threshold
                    if (cnt == 16'hFFFF)
                        cnt = hold_thr;
                end
                case (st)
                    STAGE_IDLE:
                    begin
                        if (down)
                        begin
                            cnt  = '0;
                            taps = '0;
                            ev   = EV_DOWN;
                            fire = 1'b1;
                            st   = STAGE_DOWN;
                        end
                        else
                        begin
                            ev = EV_NONE;
                        end
                    end
                    STAGE_DOWN:
                    begin
                        if (down)
                        begin
                            if (taps != '0)
                            begin
                                // held too long inside a click run: close the run
                                if (cnt > gap_thr)
                                begin
                                    ev   = clicks_to_event(taps);
                                    fire = 1'b1;
                                    cnt  = '0;
                                    taps = '0;
                                end
                            end
                            else if (cnt >= hold_thr)
                            begin
                                if (ev != EV_HOLD)
                                begin
                                    ev   = EV_HOLD;
                                    fire = 1'b1;
                                end
                            end
                            else if (cnt >= long_thr)
                            begin
                                if (ev != EV_LONG_START)
                                begin
                                    ev   = EV_LONG_START;
                                    fire = 1'b1;
                                end
                            end
                            else if (cnt >= short_thr)
                            begin
                                if (ev != EV_SHORT_START)
                                begin
                                    ev   = EV_SHORT_START;
                                    fire = 1'b1;
                                end
                            end
                        end
                        else if (cnt >= hold_thr)
                        begin
                            ev   = EV_HOLD_UP;
                            fire = 1'b1;
                            st   = STAGE_IDLE;
                        end
                        else if (cnt >= long_thr)
                        begin
                            ev   = EV_LONG_UP;
                            fire = 1'b1;
                            st   = STAGE_IDLE;
                        end
                        else if (cnt >= short_thr)
                        begin
                            ev   = EV_SHORT_UP;
                            fire = 1'b1;
                            st   = STAGE_IDLE;
                        end
                        else
                        begin
                            st = STAGE_MULTI;
                            if (taps != 8'hFF)
                                taps = taps + 8'd1;
                        end
                    end
                    STAGE_MULTI:
                    begin
                        if (down)
                        begin
                            st  = STAGE_DOWN;
                            cnt = '0;
                        end
                        else if (cnt > gap_thr)
                        begin
                            ev   = clicks_to_event(taps);
                            fire = 1'b1;
                            st   = STAGE_IDLE;
                        end
                    end
                    default: ;
                endcase
                stage_q[b]  = st;
                ticks_q[b]  = cnt;
                clicks_q[b] = taps;
                event_q[b]  = ev;
                if (st != STAGE_IDLE)
                    busy = busy + 5'd1;
                r.button = b[INDEX_W-1:0];
                r.code   = ev;
                r.fired  = fire;
                r.active = (b == 0) ? busy : '0;
                r.last   = (b == 0);
                expected_reports.push_back(r);
            end
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] ERROR %s", $time, msg);
            errors++;
        endtask

        task check_report(input report_t got);
            report_t want;
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                report($sformatf("unexpected report: button %0d event %0d",
                                 got.button, got.code));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.button !== want.button)
                    report($sformatf("button_index got %0d want %0d", got.button, want.button));
                if (got.code !== want.code)
                    report($sformatf("button %0d event_code got %0d want %0d",
                                     want.button, got.code, want.code));
                if (got.fired !== want.fired)
                    report($sformatf("button %0d fired got %0b want %0b",
                                     want.button, got.fired, want.fired));
                if (got.active !== want.active)
                    report($sformatf("button %0d active_count got %0d want %0d",
                                     want.button, got.active, want.active));
                if (got.last !== want.last)
                    report($sformatf("button %0d last got %0b want %0b",
                                     want.button, got.last, want.last));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [REG_W-1:0]     raw_levels;
    logic                 out_valid;
    logic                 out_stall;
    logic [INDEX_W-1:0]   button_index;
    logic [EVENT_W-1:0]   event_code;
    logic                 fired;
    logic [ACTIVE_W-1:0]  active_count;
    logic                 last;

    event_scoreboard board;
    logic            sender_fast;
    logic            receiver_fast;
    int              quiet_cycles;
    int              settings_used;

    // gesture generator: per button press state and ticks left before it flips
    logic [MAX_LANES-1:0] held;
    int                   span_left [MAX_LANES];

    button_event_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_levels   (raw_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .button_index (button_index),
        .event_code   (event_code),
        .fired        (fired),
        .active_count (active_count),
        .last         (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // translate a wanted pressed pattern into pin levels under the current mask
    function logic [REG_W-1:0] levels_for(input logic [REG_W-1:0] pressed);
        return ~pressed ^ board.level_mask;
    endfunction

    // scripted gestures, one column per button
    function logic [REG_W-1:0] scripted_press(input int t);
        logic [REG_W-1:0] p;
        p    = '0;
        p[0] = (t < 8);
        p[1] = (t < 3);
        p[2] = (t < 5);
        p[3] = (t == 0);
        p[4] = (t == 0) || (t == 2);
        p[5] = (t == 0) || (t == 2) || (t == 4);
        p[6] = (t == 0) || (t >= 2 && t < 8);
        for (int k = 0; k < 9; k++)
            p[7 + k] = (t <= k);
        return p;
    endfunction

    function int span_limit(input logic [REG_W-1:0] thr);
        return (thr > 16'd27) ? 30 : int'(thr) + 3;
    endfunction

    function void gesture_step();
        for (int b = 0; b < MAX_LANES; b++) begin
            if (span_left[b] <= 0)
            begin
                held[b] = ~held[b];
                span_left[b] = held[b] ? $urandom_range(1, span_limit(board.hold_thr))
                                       : $urandom_range(1, span_limit(board.gap_thr));
            end
            span_left[b]--;
        end
    endfunction

    task automatic send_tick(input logic [REG_W-1:0] lv);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        raw_levels = lv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.classify_tick(lv);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic configure(input logic [REG_W-1:0] mask, input logic [REG_W-1:0] s_thr,
                             input logic [REG_W-1:0] l_thr, input logic [REG_W-1:0] h_thr,
                             input logic [REG_W-1:0] g_thr);
        write_reg(REG_ACTIVE_LEVEL, mask);
        write_reg(REG_SHORT_PRESS, s_thr);
        write_reg(REG_LONG_PRESS, l_thr);
        write_reg(REG_LONG_HOLD, h_thr);
        write_reg(REG_CLICK_GAP, g_thr);
        settings_used++;
    endtask

    // stop sending and let every queued report come out
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input logic [REG_W-1:0] mask, input logic [REG_W-1:0] s_thr,
                                input logic [REG_W-1:0] l_thr, input logic [REG_W-1:0] h_thr,
                                input logic [REG_W-1:0] g_thr, input int count);
        drain();
        configure(mask, s_thr, l_thr, h_thr, g_thr);
        held = '0;
        for (int b = 0; b < MAX_LANES; b++)
            span_left[b] = $urandom_range(0, 3);
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0)
            begin
                sender_fast   = ($urandom_range(0, 3) == 0);
                receiver_fast = ($urandom_range(0, 3) == 0);
            end
            if (n == count / 2)
                drain();
            // mostly coherent gestures, some raw noise
            if ($urandom_range(0, 99) < 85)
            begin
                gesture_step();
                send_tick(levels_for(held));
            end
            else
            begin
                send_tick(16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // output side: random stalls, then take and check one report
    initial
    begin
        report_t got;
        int      hold_off;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold_off = receiver_fast ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall = 1'b1;
                repeat (hold_off) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.button = button_index;
            got.code   = event_code;
            got.fired  = fired;
            got.active = active_count;
            got.last   = last;
            board.check_report(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles, %0d reports outstanding",
                         quiet_cycles, board.expected_reports.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        raw_levels    = '0;
        sender_fast   = 1'b0;
        receiver_fast = 1'b0;
        quiet_cycles  = 0;
        settings_used = 1;
        held          = '0;
        board         = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset thresholds, pin extremes
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        drain();

        configure(16'h5A3C, 16'd2, 16'd4, 16'd6, 16'd2);
        // indexes past the register map must be ignored
        for (int i = REG_CLICK_GAP + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 16'($urandom_range(0, 65535)));
        repeat (3) send_tick(levels_for('0));
        for (int t = 0; t < 12; t++)
            send_tick(levels_for(scripted_press(t)));

        random_phase(16'h0000, 16'd1, 16'd3, 16'd5, 16'd1, 50);
        random_phase(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 50);
        random_phase(16'($urandom_range(0, 65535)), 16'd3, 16'd7, 16'd12, 16'd4, 50);
        random_phase(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 40);
        random_phase(16'($urandom_range(0, 65535)), 16'd4, 16'd2, 16'd9, 16'd3, 50);

        // soak: top button held throughout, button 0 tapped every other tick,
        // both sides at full rate
        drain();
        configure(16'h3C96, 16'd3, 16'd6, 16'd9, 16'd4);
        sender_fast   = 1'b1;
        receiver_fast = 1'b1;
        for (int n = 0; n < SOAK_TICKS; n++) begin
            logic [REG_W-1:0] p;
            gesture_step();
            p     = held;
            p[15] = 1'b1;
            p[0]  = (n % 2 == 0);
            send_tick(levels_for(p));
        end
        sender_fast   = 1'b0;
        receiver_fast = 1'b0;
        repeat (10) send_tick(levels_for('0));

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d scan ticks and %0d button reports across %0d threshold settings,",
                 board.ticks_seen, board.reports_seen, settings_used);
        $display("including back to back ticks, random stalls and unmapped register writes");
        if (board.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("%0d errors", board.errors);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
